// ===== rtl/q2e_pkg.sv =====
// Shared types, widths and the arctangent table for the quaternion to Euler angle block.
// No dependencies.
package q2e_pkg;

  // Field widths of the beats
  localparam int QUAT_W      = 16;
  localparam int ANGLE_W     = 16;
  localparam int FRAC_BITS   = QUAT_W - 2;
  localparam int CORDIC_DEF  = 16;

  // Internal widths
  localparam int PROD_W      = 2 * QUAT_W;
  localparam int SUM_W       = 2 * QUAT_W + 3;
  localparam int ARG_W       = (SUM_W > 33) ? SUM_W : 33;
  localparam int NORM_W      = 64;
  localparam int NORM_TOP    = 60;
  localparam int MQ_W        = 31;
  localparam int RAD_W       = 2 * MQ_W;
  localparam int ROOT_W      = 31;
  localparam int SQRT_STEPS  = 31;
  localparam int ZW          = 34;

  typedef struct packed {
    logic signed [QUAT_W-1:0] quat_w;
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] roll_angle;
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic signed [ANGLE_W-1:0] yaw_angle;
    logic                      pitch_clamped;
  } euler_t;

  // Pitch side band that rides along the square root
  typedef struct packed {
    logic signed [ARG_W-1:0] pitch_num;
    logic                    clamped;
  } pitch_side_t;

  // Front end output
  typedef struct packed {
    logic signed [SUM_W-1:0] roll_num;
    logic signed [SUM_W-1:0] roll_den;
    logic signed [SUM_W-1:0] yaw_num;
    logic signed [SUM_W-1:0] yaw_den;
    logic [RAD_W-1:0]        rad;
    pitch_side_t             side;
  } front_t;

  // atan(2^-i) in units of 2^-32 turn, rounded
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

endpackage

// ===== rtl/q2e_front.sv =====
// Front end: input saturation, products, atan2 operands and the asin argument.
// Depends on q2e_pkg.
module q2e_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  q2e_pkg::quat_t   quat,
  output logic             out_valid,
  output q2e_pkg::front_t  front
);
  import q2e_pkg::*;

  localparam logic signed [QUAT_W-1:0] Q_ONE = QUAT_W'(1) << FRAC_BITS;
  localparam logic signed [SUM_W-1:0]  S_ONE = SUM_W'(1) << (2 * FRAC_BITS);
  localparam int SH_R = (2 * FRAC_BITS >= 30) ? 2 * FRAC_BITS - 30 : 0;
  localparam int SH_L = (2 * FRAC_BITS >= 30) ? 0 : 30 - 2 * FRAC_BITS;
  localparam logic [63:0]      MQ_MAX = 64'd1 << 30;
  localparam logic [RAD_W-1:0] RAD_ONE = RAD_W'(1) << 60;

  function automatic logic signed [QUAT_W-1:0] sat(input logic signed [QUAT_W-1:0] v);
    logic signed [QUAT_W-1:0] r;
    r = v;
    if (v > Q_ONE) r = Q_ONE;
    if (v < -Q_ONE) r = -Q_ONE;
    return r;
  endfunction

  logic v1, v2, v3, v4, v5, v6;
  logic signed [QUAT_W-1:0] w1, x1, y1, z1;
  logic signed [PROD_W-1:0] ww2, xx2, yy2, zz2, wx2, yz2, wz2, xy2, wy2, xz2;
  logic signed [SUM_W-1:0]  rn3, rd3, yn3, yd3, s3;
  front_t f4, f5, f6;
  logic [MQ_W-1:0]  mq4;
  logic [RAD_W-1:0] sq5;

  logic signed [SUM_W-1:0] s_sat;
  logic                    s_clamp;
  logic [SUM_W-1:0]        s_mag;
  logic [63:0]             mq_wide;
  logic [MQ_W-1:0]         mq_next;

  // valid line
  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6} <= '0;
    end else begin
      {v1, v2, v3, v4, v5, v6} <= {in_valid, v1, v2, v3, v4, v5};
    end
  end

  // stage 1: saturate inputs to +-1.0
  always_ff @(posedge clk) begin
    w1 <= sat(quat.quat_w);
    x1 <= sat(quat.quat_x);
    y1 <= sat(quat.quat_y);
    z1 <= sat(quat.quat_z);
  end

  // stage 2: products
  always_ff @(posedge clk) begin
    ww2 <= w1 * w1;
    xx2 <= x1 * x1;
    yy2 <= y1 * y1;
    zz2 <= z1 * z1;
    wx2 <= w1 * x1;
    yz2 <= y1 * z1;
    wz2 <= w1 * z1;
    xy2 <= x1 * y1;
    wy2 <= w1 * y1;
    xz2 <= x1 * z1;
  end

  // stage 3: atan2 operands and asin argument
  always_ff @(posedge clk) begin
    rn3 <= (SUM_W'(wx2) + SUM_W'(yz2)) <<< 1;
    rd3 <= SUM_W'(ww2) - SUM_W'(xx2) - SUM_W'(yy2) + SUM_W'(zz2);
    yn3 <= (SUM_W'(wz2) + SUM_W'(xy2)) <<< 1;
    yd3 <= SUM_W'(ww2) + SUM_W'(xx2) - SUM_W'(yy2) - SUM_W'(zz2);
    s3  <= (SUM_W'(wy2) - SUM_W'(xz2)) <<< 1;
  end

  // stage 4: saturate asin argument, rescale magnitude to Q.30
  always_comb begin
    s_sat   = s3;
    s_clamp = 1'b0;
    if (s3 > S_ONE) begin
      s_sat   = S_ONE;
      s_clamp = 1'b1;
    end else if (s3 < -S_ONE) begin
      s_sat   = -S_ONE;
      s_clamp = 1'b1;
    end
    s_mag   = s_sat[SUM_W-1] ? SUM_W'(-s_sat) : SUM_W'(s_sat);
    mq_wide = (64'(s_mag) >> SH_R) << SH_L;
    mq_next = (mq_wide > MQ_MAX) ? MQ_W'(MQ_MAX) : mq_wide[MQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    f4.roll_num  <= rn3;
    f4.roll_den  <= rd3;
    f4.yaw_num   <= yn3;
    f4.yaw_den   <= yd3;
    f4.rad       <= '0;
    f4.side.clamped   <= s_clamp;
    f4.side.pitch_num <= s3[SUM_W-1] ? -ARG_W'(mq_next) : ARG_W'(mq_next);
    mq4          <= mq_next;
  end

  // stage 5: square of the rescaled argument
  always_ff @(posedge clk) begin
    f5  <= f4;
    sq5 <= RAD_W'(mq4) * RAD_W'(mq4);
  end

  // stage 6: radicand 1 - s^2 in Q.60
  always_ff @(posedge clk) begin
    f6.roll_num <= f5.roll_num;
    f6.roll_den <= f5.roll_den;
    f6.yaw_num  <= f5.yaw_num;
    f6.yaw_den  <= f5.yaw_den;
    f6.side     <= f5.side;
    f6.rad      <= RAD_ONE - sq5;
  end

  assign out_valid = v6;
  assign front     = f6;

endmodule

// ===== rtl/q2e_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, with a pitch side band.
// Depends on q2e_pkg.
module q2e_sqrt (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [q2e_pkg::RAD_W-1:0] rad,
  input  q2e_pkg::pitch_side_t  side_in,
  output logic                  out_valid,
  output logic [q2e_pkg::ROOT_W-1:0] root,
  output q2e_pkg::pitch_side_t  side_out
);
  import q2e_pkg::*;

  logic [RAD_W-1:0] rem_q [SQRT_STEPS+1];
  logic [RAD_W-1:0] res_q [SQRT_STEPS+1];
  pitch_side_t      side_q [SQRT_STEPS+1];
  logic             vld_q [SQRT_STEPS+1];

  assign rem_q[0]  = rad;
  assign res_q[0]  = '0;
  assign side_q[0] = side_in;
  assign vld_q[0]  = in_valid;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * (SQRT_STEPS - 1 - k));
    logic [RAD_W:0] trial;

    // one restoring step
    assign trial = {1'b0, res_q[k]} + {1'b0, BIT};

    always_ff @(posedge clk) begin
      side_q[k+1] <= side_q[k];
      if ({1'b0, rem_q[k]} >= trial) begin
        rem_q[k+1] <= rem_q[k] - trial[RAD_W-1:0];
        res_q[k+1] <= (res_q[k] >> 1) + BIT;
      end else begin
        rem_q[k+1] <= rem_q[k];
        res_q[k+1] <= res_q[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end
  end

  assign out_valid = vld_q[SQRT_STEPS];
  assign root      = res_q[SQRT_STEPS][ROOT_W-1:0];
  assign side_out  = side_q[SQRT_STEPS];

endmodule

// ===== rtl/q2e_atan.sv =====
// Pipelined four-quadrant atan2: magnitude, normalize, CORDIC vectoring, quadrant fix.
// Depends on q2e_pkg.
module q2e_atan #(
  parameter int STAGES = q2e_pkg::CORDIC_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic signed [q2e_pkg::ARG_W-1:0]   num,
  input  logic signed [q2e_pkg::ARG_W-1:0]   den,
  output logic                            out_valid,
  output logic signed [q2e_pkg::ANGLE_W-1:0] angle
);
  import q2e_pkg::*;

  localparam int LSTEPS = 6;
  localparam int C0     = 2 + LSTEPS;       // stage holding normalized operands
  localparam int LAT    = C0 + STAGES + 2;
  localparam int SH     = 32 - ANGLE_W;
  localparam logic signed [ZW-1:0] QUARTER = ZW'(1) << 30;
  localparam logic signed [ZW-1:0] HALF    = ZW'(1) << 31;
  localparam logic signed [ZW-1:0] ROUND   = (SH > 0) ? (ZW'(1) << (SH - 1)) : '0;

  typedef struct packed {
    logic v;
    logic zero;
    logic dneg;
    logic nneg;
  } ctl_t;

  ctl_t ctl_q [LAT+1];
  logic [NORM_W-1:0] ax1, ay1;
  logic [NORM_W-1:0] nx_q [LSTEPS+1];
  logic [NORM_W-1:0] ny_q [LSTEPS+1];
  logic signed [NORM_W-1:0] cx_q [STAGES];
  logic signed [NORM_W-1:0] cy_q [STAGES];
  logic signed [ZW-1:0]     cz_q [STAGES+1];
  logic signed [ZW-1:0]     quad;
  logic signed [ZW-1:0]     zc, qa, qb, rnd;

  // control line
  assign ctl_q[0] = '{v: in_valid, zero: (num == '0) && (den == '0),
                      dneg: den[ARG_W-1], nneg: num[ARG_W-1]};

  for (genvar s = 0; s < LAT; s++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_q[s+1] <= '0;
      end else begin
        ctl_q[s+1] <= ctl_q[s];
      end
    end
  end

  // stage 1: magnitudes
  always_ff @(posedge clk) begin
    ax1 <= NORM_W'(den[ARG_W-1] ? ARG_W'(-den) : ARG_W'(den));
    ay1 <= NORM_W'(num[ARG_W-1] ? ARG_W'(-num) : ARG_W'(num));
  end

  // stage 2: right shift when the larger operand is too long
  logic [NORM_W-1:0] o1;
  logic [2:0]        rs;
  always_comb begin
    o1 = ax1 | ay1;
    rs = '0;
    for (int b = NORM_TOP; b < NORM_W; b++) begin
      if (o1[b]) rs = 3'(b - NORM_TOP + 1);
    end
  end

  always_ff @(posedge clk) begin
    nx_q[0] <= ax1 >> rs;
    ny_q[0] <= ay1 >> rs;
  end

  // stages 3..8: left normalize, halving shift steps
  for (genvar j = 0; j < LSTEPS; j++) begin : g_norm
    localparam int K = 32 >> j;
    logic [NORM_W-1:0] o;
    assign o = nx_q[j] | ny_q[j];
    always_ff @(posedge clk) begin
      if (o[NORM_TOP-1 -: K] == '0) begin
        nx_q[j+1] <= nx_q[j] << K;
        ny_q[j+1] <= ny_q[j] << K;
      end else begin
        nx_q[j+1] <= nx_q[j];
        ny_q[j+1] <= ny_q[j];
      end
    end
  end

  assign cx_q[0] = nx_q[LSTEPS];
  assign cy_q[0] = ny_q[LSTEPS];
  assign cz_q[0] = '0;

  // CORDIC vectoring, one rotation per stage
  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    localparam logic signed [ZW-1:0] T = ZW'(ATAN_TAB[i]);
    always_ff @(posedge clk) begin
      if (cy_q[i] >= 0) begin
        cz_q[i+1] <= cz_q[i] + T;
      end else begin
        cz_q[i+1] <= cz_q[i] - T;
      end
    end
    if (i < STAGES - 1) begin : g_xy
      always_ff @(posedge clk) begin
        if (cy_q[i] >= 0) begin
          cx_q[i+1] <= cx_q[i] + (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] - (cx_q[i] >>> i);
        end else begin
          cx_q[i+1] <= cx_q[i] - (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] + (cx_q[i] >>> i);
        end
      end
    end
  end

  // clamp into the quadrant, then map to the full circle
  always_comb begin
    zc = cz_q[STAGES];
    if (zc < 0) zc = '0;
    if (zc > QUARTER) zc = QUARTER;
    qa = ctl_q[C0+STAGES].dneg ? HALF - zc : zc;
    qb = ctl_q[C0+STAGES].nneg ? -qa : qa;
    if (ctl_q[C0+STAGES].zero) qb = '0;
  end

  always_ff @(posedge clk) begin
    quad <= qb;
  end

  // round half up to the output width, wrapping
  assign rnd = quad + ROUND;

  always_ff @(posedge clk) begin
    angle <= rnd[SH +: ANGLE_W];
  end

  assign out_valid = ctl_q[LAT].v;

endmodule

// ===== rtl/q2e_delay.sv =====
// Fixed-depth register delay line for results that wait on a longer path.
// Depends on nothing.
module q2e_delay #(
  parameter int DEPTH = 1,
  parameter int WIDTH = 1
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] tap [DEPTH];

  always_ff @(posedge clk) begin
    tap[0] <= din;
  end

  for (genvar k = 1; k < DEPTH; k++) begin : g_tap
    always_ff @(posedge clk) begin
      tap[k] <= tap[k-1];
    end
  end

  assign dout = tap[DEPTH-1];

endmodule

// ===== rtl/quaternion_to_euler_angles.sv =====
// Top level: quaternion in, roll / pitch / yaw binary angles out.
// Depends on q2e_pkg, q2e_front, q2e_sqrt, q2e_atan, q2e_delay.
//
//   beat     ports                 qualifier
//   -------  --------------------  -------------------------
//   input    quat (quat_t)         start && !busy
//   result   euler (euler_t)       done, single cycle strobe
//
// One quaternion enters every cycle; busy is always low. Each beat passes the
// front end, the 31 step square root of the pitch path, then the CORDIC atan2
// pipeline. Roll and yaw run their atan2 early and wait in a delay line.
// Reset clears the valid and control bits only; the receiver cannot stall,
// so beats never wait.
module quaternion_to_euler_angles #(
  parameter int CORDIC_STAGES = q2e_pkg::CORDIC_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  q2e_pkg::quat_t  quat,
  output logic            done,
  output q2e_pkg::euler_t euler
);
  import q2e_pkg::*;

  localparam int ATAN_LAT = CORDIC_STAGES + 10;

  front_t      front;
  logic        front_valid;
  logic        sq_valid;
  logic [ROOT_W-1:0] root;
  pitch_side_t side;
  logic signed [ANGLE_W-1:0] roll_a, yaw_a, pitch_a;
  logic [2*ANGLE_W-1:0]      ry_late;
  logic                      clamp_late;

  assign busy = 1'b0;

  q2e_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .quat      (quat),
    .out_valid (front_valid),
    .front     (front)
  );

  // roll and yaw
  q2e_atan #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .num       (ARG_W'(front.roll_num)),
    .den       (ARG_W'(front.roll_den)),
    .out_valid (),
    .angle     (roll_a)
  );

  q2e_atan #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .num       (ARG_W'(front.yaw_num)),
    .den       (ARG_W'(front.yaw_den)),
    .out_valid (),
    .angle     (yaw_a)
  );

  q2e_delay #(.DEPTH(SQRT_STEPS), .WIDTH(2 * ANGLE_W)) u_ry_dly (
    .clk  (clk),
    .din  ({roll_a, yaw_a}),
    .dout (ry_late)
  );

  // pitch: asin(s) = atan2(s, sqrt(1 - s^2))
  q2e_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .rad       (front.rad),
    .side_in   (front.side),
    .out_valid (sq_valid),
    .root      (root),
    .side_out  (side)
  );

  q2e_atan #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .num       (side.pitch_num),
    .den       (ARG_W'(root)),
    .out_valid (done),
    .angle     (pitch_a)
  );

  q2e_delay #(.DEPTH(ATAN_LAT), .WIDTH(1)) u_clamp_dly (
    .clk  (clk),
    .din  (side.clamped),
    .dout (clamp_late)
  );

  // result beat
  assign euler.roll_angle    = ry_late[2*ANGLE_W-1:ANGLE_W];
  assign euler.yaw_angle     = ry_late[ANGLE_W-1:0];
  assign euler.pitch_angle   = pitch_a;
  assign euler.pitch_clamped = clamp_late;

endmodule
